>>> rtl/crcfb_pkg.sv
// Shared types and constants for the CRC-16 command frame builder.
// No dependencies; every module of the block imports this package.
package crcfb_pkg;

   typedef enum logic [1:0] {
      KIND_WRITE1 = 2'd0,
      KIND_WRITE4 = 2'd1,
      KIND_QUERY  = 2'd2,
      KIND_NONE   = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [31:0]  address;
      logic [31:0]  value;
      logic [7:0]   node;
   } cmd_entry_type;

   // Front to queue
   typedef struct packed {
      logic          push;
      cmd_entry_type entry;
   } queue_push_type;

   // Queue to back
   typedef struct packed {
      logic          valid;
      cmd_entry_type entry;
   } queue_head_type;

   typedef enum logic {
      BACK_IDLE = 1'b0,
      BACK_SEND = 1'b1
   } back_state_type;

   localparam logic [1:0] CSR_WRITE_CODE = 2'd0;
   localparam logic [1:0] CSR_ACK_FLAG   = 2'd1;

   localparam logic [7:0]  WRITE_CODE_RESET = 8'h01;
   localparam logic [7:0]  ACK_FLAG_RESET   = 8'hFF;
   localparam logic [7:0]  HEAD0            = 8'hD5;
   localparam logic [7:0]  HEAD1            = 8'h5D;
   localparam logic [7:0]  QUERY_CODE       = 8'h0A;
   localparam logic [7:0]  LEN_ONE          = 8'h06;
   localparam logic [7:0]  LEN_FOUR         = 8'h09;
   localparam logic [15:0] CRC_INIT         = 16'hFFFF;
   localparam logic [15:0] CRC_POLY         = 16'hA001;

   localparam logic [4:0] POS_LEN     = 5'd4;
   localparam logic [4:0] POS_PAYLOAD = 5'd5;

   // Position of the closing trailer byte for each frame kind
   function automatic logic [4:0] frame_last_pos(cmd_kind_type kind);
      logic [4:0] pos;
      unique case (kind)
         KIND_WRITE1: pos = 5'd13;
         KIND_WRITE4: pos = 5'd16;
         default:     pos = 5'd8;
      endcase
      return pos;
   endfunction

endpackage

>>> rtl/crc16_command_frame_builder.sv
// CRC-16 command frame builder.
// Commands enter on the req_ channel (opcode, address, value, node id) and
// are accepted on a clock edge with req_valid high and req_stall low.
// Opcode 3 is accepted and discarded. Each other command becomes one frame
// on the rsp_ channel, one word per cycle: 14 words for a one-byte write,
// 17 for a four-byte write, 9 for a query; rsp_last_byte marks the final
// trailer word. A front register and a two-entry queue let commands be
// taken while a frame is still going out.
// The first word of a frame passes the front register, a queue slot and the
// serializer's command register before it reaches the rsp_ output register.
// The byte serializer emits one word per cycle while rsp_stall allows it;
// back-to-back frames follow with no gap.
// When rsp_stall is high the held word stays on rsp_ and the serializer
// waits; the queue fills and then req_stall rises.
// csr_ writes set the write command code (index 0) and acknowledge byte
// (index 1); write them only while no frame is pending.
// Synchronous reset empties the queue, drops any frame in progress and
// restores the register defaults 0x01 and 0xFF.
module crc16_command_frame_builder import crcfb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_param_address,
   input  logic [31:0] req_param_value,
   input  logic [7:0]  req_node_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_last_byte,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_write_data
);

   logic [7:0] write_code_ff, write_code_in;
   logic [7:0] ack_flag_ff, ack_flag_in;

   queue_push_type push;
   queue_head_type head;
   logic           queue_full;
   logic           pop;

   always_comb begin
      write_code_in = write_code_ff;
      ack_flag_in   = ack_flag_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_WRITE_CODE: write_code_in = csr_write_data;
            CSR_ACK_FLAG:   ack_flag_in   = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_code_ff <= WRITE_CODE_RESET;
         ack_flag_ff   <= ACK_FLAG_RESET;
      end else begin
         write_code_ff <= write_code_in;
         ack_flag_ff   <= ack_flag_in;
      end
   end

   crcfb_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_param_address (req_param_address),
      .req_param_value   (req_param_value),
      .req_node_id       (req_node_id),
      .queue_full        (queue_full),
      .push_out          (push)
   );

   crcfb_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .full    (queue_full),
      .head    (head),
      .pop     (pop)
   );

   crcfb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .write_code     (write_code_ff),
      .ack_flag       (ack_flag_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

endmodule

>>> rtl/crcfb_front.sv
// Front end of the frame builder: accepts commands, drops unused opcodes.
// Depends on crcfb_pkg; feeds crcfb_queue.
module crcfb_front import crcfb_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic [1:0]     req_opcode,
   input  logic [31:0]    req_param_address,
   input  logic [31:0]    req_param_value,
   input  logic [7:0]     req_node_id,
   input  logic           queue_full,
   output queue_push_type push_out
);

   logic          valid_ff, valid_in;
   cmd_entry_type entry_ff;
   logic          push;
   logic          take;
   logic          keep;

   assign push      = valid_ff && !queue_full;
   assign req_stall = valid_ff && !push;
   assign take      = req_valid && !req_stall;
   // opcode 3 is accepted and dropped here
   assign keep      = take && (cmd_kind_type'(req_opcode) != KIND_NONE);

   always_comb begin
      valid_in = valid_ff;
      if (push) begin
         valid_in = 1'b0;
      end
      if (keep) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (keep) begin
         entry_ff.kind    <= cmd_kind_type'(req_opcode);
         entry_ff.address <= req_param_address;
         entry_ff.value   <= req_param_value;
         entry_ff.node    <= req_node_id;
      end
   end

   assign push_out.push  = push;
   assign push_out.entry = entry_ff;

endmodule

>>> rtl/crcfb_queue.sv
// Two-entry command queue between the front end and the frame serializer.
// Depends on crcfb_pkg.
module crcfb_queue import crcfb_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  queue_push_type push_in,
   output logic           full,
   output queue_head_type head,
   input  logic           pop
);

   cmd_entry_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign full    = (count_ff == 2'd2);
   assign do_push = push_in.push && !full;
   assign do_pop  = pop && (count_ff != 2'd0);

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_in.entry;
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.entry = slot_ff[rd_ptr_ff];

endmodule

>>> rtl/crcfb_back.sv
// Frame serializer: walks one queued command out byte by byte with CRC-16.
// Depends on crcfb_pkg; pops crcfb_queue and drives the result register.
module crcfb_back import crcfb_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           pop,
   input  logic [7:0]     write_code,
   input  logic [7:0]     ack_flag,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic [7:0]     rsp_frame_byte,
   output logic           rsp_last_byte
);

   function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   back_state_type state_ff, state_in;
   cmd_entry_type  entry_ff;
   logic [4:0]     pos_ff, pos_in;
   logic [15:0]    crc_ff, crc_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_byte_ff, rsp_byte_in;
   logic           rsp_last_ff, rsp_last_in;

   logic        advance;
   logic        emit;
   logic        at_last;
   logic [4:0]  last_pos;
   logic [4:0]  pay_idx;
   logic [63:0] payload;
   logic [7:0]  cur_byte;
   logic        in_crc;

   assign last_pos = frame_last_pos(entry_ff.kind);
   assign at_last  = (pos_ff == last_pos);
   assign advance  = !rsp_valid_ff || !rsp_stall;
   assign emit     = (state_ff == BACK_SEND) && advance;
   // load the next command on the cycle the trailer goes out
   assign pop      = head.valid && ((state_ff == BACK_IDLE) || (emit && at_last));
   assign in_crc   = (pos_ff >= 5'd2) && (pos_ff < last_pos - 5'd3);

   // one-byte writes carry only the low value byte
   assign payload  = {entry_ff.address,
                      (entry_ff.kind == KIND_WRITE1) ? {entry_ff.value[7:0], 24'h000000}
                                                     : entry_ff.value};
   assign pay_idx  = pos_ff - POS_PAYLOAD;

   always_comb begin
      if (pos_ff == last_pos) begin
         cur_byte = HEAD0;
      end else if (pos_ff == last_pos - 5'd1) begin
         cur_byte = HEAD1;
      end else if (pos_ff == last_pos - 5'd2) begin
         cur_byte = crc_ff[15:8];
      end else if (pos_ff == last_pos - 5'd3) begin
         cur_byte = crc_ff[7:0];
      end else if (pos_ff == 5'd0) begin
         cur_byte = HEAD0;
      end else if (pos_ff == 5'd1) begin
         cur_byte = HEAD1;
      end else if (pos_ff == 5'd2) begin
         cur_byte = (entry_ff.kind == KIND_QUERY) ? QUERY_CODE : write_code;
      end else if (pos_ff == 5'd3) begin
         cur_byte = ack_flag;
      end else if (pos_ff == POS_LEN) begin
         case (entry_ff.kind)
            KIND_QUERY:  cur_byte = entry_ff.node;
            KIND_WRITE1: cur_byte = LEN_ONE;
            default:     cur_byte = LEN_FOUR;
         endcase
      end else begin
         cur_byte = payload[(3'd7 - pay_idx[2:0]) * 8 +: 8];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (head.valid) begin
               state_in = BACK_SEND;
            end
         end
         BACK_SEND: begin
            if (emit && at_last && !head.valid) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // datapath and result register
   always_comb begin
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = cur_byte;
         rsp_last_in  = at_last;
         pos_in       = pos_ff + 5'd1;
         if (in_crc) begin
            crc_in = crc_byte(crc_ff, cur_byte);
         end
      end
      if (pop) begin
         pos_in = 5'd0;
         crc_in = CRC_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      crc_ff      <= crc_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      if (pop) begin
         entry_ff <= head.entry;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = rsp_byte_ff;
   assign rsp_last_byte  = rsp_last_ff;

endmodule

>>> test/tb_top.sv
// Self-checking testbench for crc16_command_frame_builder: a table of commands,
// then random ones, under random idling; each frame word is checked in order.
// Depends on crcfb_pkg and the crc16_command_frame_builder RTL only.
`timescale 1ns / 1ps

module tb_top;
   import crcfb_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 24;
   localparam int PHASE_ITEMS  = 95;

   // Register indexes past the two real registers; writes there must do nothing
   localparam logic [1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [1:0] CSR_SPARE_HI = 2'd3;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } frame_word_type;

   typedef struct packed {
      cmd_entry_type cmd;
      logic [4:0]    words;
   } stim_row_type;

   localparam stim_row_type DIRECTED [0:11] = '{
      '{'{KIND_WRITE1, 32'h0000_0000, 32'h0000_0000, 8'h00}, 5'd14},
      '{'{KIND_WRITE1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF}, 5'd14},
      '{'{KIND_WRITE1, 32'h8000_0001, 32'hFFFF_FF80, 8'h7F}, 5'd14},
      '{'{KIND_WRITE4, 32'h0000_0000, 32'h0000_0000, 8'h00}, 5'd17},
      '{'{KIND_WRITE4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF}, 5'd17},
      '{'{KIND_WRITE4, 32'hAAAA_AAAA, 32'h5555_5555, 8'hA5}, 5'd17},
      '{'{KIND_QUERY,  32'h0000_0000, 32'h0000_0000, 8'h00}, 5'd9},
      '{'{KIND_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF}, 5'd9},
      '{'{KIND_QUERY,  32'hDEAD_BEEF, 32'h0123_4567, 8'h80}, 5'd9},
      '{'{KIND_NONE,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF}, 5'd0},
      '{'{KIND_NONE,   32'h0000_0000, 32'h0000_0000, 8'h00}, 5'd0},
      '{'{KIND_WRITE4, 32'h5555_5555, 32'hAAAA_AAAA, 8'h5A}, 5'd17}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_opcode;
   logic [31:0] req_param_address;
   logic [31:0] req_param_value;
   logic [7:0]  req_node_id;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_frame_byte;
   logic        rsp_last_byte;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [7:0]  csr_write_data;

   frame_word_type pending_words[$];
   logic [7:0]     cur_write_code;
   logic [7:0]     cur_ack_flag;
   logic           no_idle;
   int             mismatch_count;
   int             cycle_count = 0;

   crc16_command_frame_builder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_param_address (req_param_address),
      .req_param_value   (req_param_value),
      .req_node_id       (req_node_id),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_last_byte     (rsp_last_byte),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** crc16_command_frame_builder: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(99) < 20);
   end

   task automatic flag_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch on %s: expected %0h, got %0h", what, want, got);
   endtask

   // Compare each accepted word against the oldest pending one
   always @(posedge clock) begin
      frame_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            flag_mismatch("word with nothing pending", 32'h0, 32'(rsp_frame_byte));
         end else begin
            w = pending_words.pop_front();
            if (rsp_frame_byte !== w.data)
               flag_mismatch("frame_byte", 32'(w.data), 32'(rsp_frame_byte));
            if (rsp_last_byte !== w.last)
               flag_mismatch("last_byte", 32'(w.last), 32'(rsp_last_byte));
         end
      end
   end

   function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++)
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   // Build the whole frame a command should produce and queue its words
   task automatic queue_frame(input cmd_entry_type c, output int count);
      logic [7:0]     body[$];
      logic [15:0]    crc;
      frame_word_type w;
      count = 0;
      if (c.kind == KIND_NONE)
         return;
      if (c.kind == KIND_QUERY) begin
         body.push_back(QUERY_CODE);
         body.push_back(cur_ack_flag);
         body.push_back(c.node);
      end else begin
         body.push_back(cur_write_code);
         body.push_back(cur_ack_flag);
         body.push_back(c.kind == KIND_WRITE1 ? LEN_ONE : LEN_FOUR);
         for (int s = 3; s >= 0; s--)
            body.push_back(c.address[s*8 +: 8]);
         if (c.kind == KIND_WRITE1) begin
            body.push_back(c.value[7:0]);
         end else begin
            for (int s = 3; s >= 0; s--)
               body.push_back(c.value[s*8 +: 8]);
         end
      end
      crc = CRC_INIT;
      foreach (body[i])
         crc = crc16_update(crc, body[i]);
      body.push_front(HEAD1);
      body.push_front(HEAD0);
      body.push_back(crc[7:0]);
      body.push_back(crc[15:8]);
      body.push_back(HEAD1);
      body.push_back(HEAD0);
      foreach (body[i]) begin
         w.data = body[i];
         w.last = (i == body.size() - 1);
         pending_words.push_back(w);
      end
      count = body.size();
   endtask

   task automatic send_command(input cmd_entry_type c, output int count);
      if (!no_idle && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < 30)
            @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= c.kind;
      req_param_address <= c.address;
      req_param_value   <= c.value;
      req_node_id       <= c.node;
      do
         @(posedge clock);
      while (req_stall);
      queue_frame(c, count);
   endtask

   // Drop valid, let every pending frame drain, then give the block time to go idle
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [7:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      if (idx == CSR_WRITE_CODE)
         cur_write_code = data;
      else if (idx == CSR_ACK_FLAG)
         cur_ack_flag = data;
   endtask

   function automatic logic [31:0] random_word();
      case ($urandom_range(7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic cmd_entry_type random_command();
      cmd_entry_type c;
      int            pick;
      pick = $urandom_range(99);
      if (pick < 8)
         c.kind = KIND_NONE;
      else if (pick < 38)
         c.kind = KIND_WRITE1;
      else if (pick < 69)
         c.kind = KIND_WRITE4;
      else
         c.kind = KIND_QUERY;
      c.address = random_word();
      c.value   = random_word();
      c.node    = 8'($urandom_range(255));
      return c;
   endfunction

   task automatic walk_table();
      int count;
      foreach (DIRECTED[i]) begin
         send_command(DIRECTED[i].cmd, count);
         if (count != DIRECTED[i].words)
            flag_mismatch("frame length", 32'(DIRECTED[i].words), 32'(count));
      end
   endtask

   task automatic run_random(input int n);
      int count;
      repeat (n) send_command(random_command(), count);
   endtask

   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_opcode        <= KIND_NONE;
      req_param_address <= '0;
      req_param_value   <= '0;
      req_node_id       <= '0;
      csr_write_enable  <= 1'b0;
      csr_index         <= CSR_WRITE_CODE;
      csr_write_data    <= '0;
      no_idle           = 1'b0;
      mismatch_count    = 0;
      cur_write_code    = WRITE_CODE_RESET;
      cur_ack_flag      = ACK_FLAG_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Defaults after reset
      walk_table();
      settle();

      // Write code equal to the query code; spare indexes must not alias
      write_csr(CSR_WRITE_CODE, QUERY_CODE);
      write_csr(CSR_ACK_FLAG, 8'h00);
      write_csr(CSR_SPARE_LO, 8'h33);
      write_csr(CSR_SPARE_HI, 8'hCC);
      walk_table();
      run_random(PHASE_ITEMS);
      settle();

      // Long stretch with no idling on either side
      write_csr(CSR_WRITE_CODE, 8'h00);
      write_csr(CSR_ACK_FLAG, 8'hFF);
      no_idle = 1'b1;
      run_random(PHASE_ITEMS);
      settle();
      no_idle = 1'b0;

      write_csr(CSR_WRITE_CODE, 8'hFF);
      write_csr(CSR_ACK_FLAG, 8'h80);
      run_random(PHASE_ITEMS);
      settle();

      repeat (2) begin
         write_csr(CSR_SPARE_HI, 8'($urandom_range(255)));
         write_csr(CSR_WRITE_CODE, 8'($urandom_range(255)));
         write_csr(CSR_ACK_FLAG, 8'($urandom_range(255)));
         write_csr(CSR_SPARE_LO, 8'($urandom_range(255)));
         run_random(PHASE_ITEMS);
         settle();
      end

      if (mismatch_count == 0)
         $display("** crc16_command_frame_builder: PASSED **");
      else
         $display("** crc16_command_frame_builder: FAILED **");
      $finish;
   end

endmodule

>>> sim.f
rtl/crcfb_pkg.sv
rtl/crcfb_front.sv
rtl/crcfb_queue.sv
rtl/crcfb_back.sv
rtl/crc16_command_frame_builder.sv
test/tb_top.sv
